// File: rtl/jbt_pkg.sv
// Shared types, codes and character constants of the JSON byte tokenizer.
`default_nettype none

package jbt_pkg;

    // Default sizes of the token table and of the longest document.
    localparam int MAX_TOKENS_DEF     = 64;
    localparam int MAX_TEXT_BYTES_DEF = 65536;

    // Stream word widths.
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 3;

    // Character codes used by the lexer.
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'd32;
    localparam logic [7:0] CH_DEL      = 8'd127;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_DIGIT_0  = 8'd48;
    localparam logic [7:0] CH_DIGIT_9  = 8'd57;
    localparam logic [7:0] CH_UPPER_A  = 8'd65;
    localparam logic [7:0] CH_UPPER_F  = 8'd70;
    localparam logic [7:0] CH_LOWER_A  = 8'd97;
    localparam logic [7:0] CH_LOWER_F  = 8'd102;
    localparam logic [7:0] CH_B        = 8'h62;
    localparam logic [7:0] CH_F        = 8'h66;
    localparam logic [7:0] CH_N        = 8'h6E;
    localparam logic [7:0] CH_R        = 8'h72;
    localparam logic [7:0] CH_T        = 8'h74;
    localparam logic [7:0] CH_U        = 8'h75;

    // Lexer mode.
    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_STR,
        MODE_ESC,
        MODE_HEX,
        MODE_PRIM,
        MODE_HALT
    } mode_t;

    // Result event codes.
    typedef enum logic [2:0] {
        EV_OPENED,
        EV_CLOSED,
        EV_STRING,
        EV_PRIM,
        EV_ERROR,
        EV_DONE
    } event_t;

    // Token kinds.
    typedef enum logic [1:0] {
        TK_PRIM,
        TK_STRING,
        TK_OBJECT,
        TK_ARRAY
    } tkind_t;

    // Error codes.
    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_NO_TOKENS,
        ERR_INVALID,
        ERR_PARTIAL
    } err_t;

    // Datapath selectors.
    typedef enum logic [1:0] {PS_KEEP, PS_BP, PS_BP1} ps_sel_t;
    typedef enum logic [1:0] {CS_KEEP, CS_NFT_M1, CS_RD_PARENT, CS_NFT} cs_sel_t;
    typedef enum logic [1:0] {RD_NFT_M1, RD_CS, RD_PARENT} rd_sel_t;
    typedef enum logic [1:0] {PUSH_NEW, PUSH_CLOSED, PUSH_DONE} push_sel_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_IDLE_BYTE,
        ST_NEW_CONT,
        ST_NEW_STR,
        ST_NEW_PRIM,
        ST_NEW_EPRIM,
        ST_INC,
        ST_WALK,
        ST_COMMA,
        ST_STRICT,
        ST_ADV,
        ST_END,
        ST_DONE,
        ST_FLUSH
    } ctrl_state_t;

    // One result word, without the last flag.
    typedef struct packed {
        err_t        code;
        logic [6:0]  child;
        logic [6:0]  parent;
        logic [16:0] endp;
        logic [15:0] startp;
        tkind_t      kind;
        logic [5:0]  idx;
        event_t      ev;
    } res_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load_byte;
        logic      mode_we;
        mode_t     mode_val;
        logic      hex_load;
        logic      hex_dec;
        ps_sel_t   ps_sel;
        logic      acf_set;
        logic      acf_clr;
        cs_sel_t   cs_sel;
        logic      rd_en;
        rd_sel_t   rd_sel;
        logic      new_tok;
        tkind_t    new_kind;
        logic      new_open;
        logic      close_wr;
        logic      inc_wr;
        logic      open_inc;
        logic      open_dec;
        logic      bp_inc;
        logic      push;
        push_sel_t push_sel;
        event_t    push_ev;
        logic      fail;
        err_t      err_code;
        logic      restart;
        logic      flush;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic   last;
        logic   zero;
        logic   overlong;
        mode_t  mode;
        logic   is_quote;
        logic   is_bslash;
        logic   is_esc_ok;
        logic   is_u;
        logic   is_hex;
        logic   is_ws;
        logic   is_delim;
        logic   is_ctl;
        logic   is_open;
        logic   is_obj_open;
        logic   is_close;
        logic   is_colon;
        logic   is_comma;
        logic   is_prim_start;
        logic   strict;
        logic   can_push;
        logic   nft_zero;
        logic   nft_full;
        logic   cs_valid;
        logic   cs_top;
        logic   acf;
        logic   hex_one;
        logic   rd_open;
        logic   rd_kind_match;
        logic   rd_par_top;
        logic   rd_par_ok;
        tkind_t rd_kind;
        logic   rd_child_zero;
    } status_t;

endpackage

`default_nettype wire

// File: rtl/jbt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module jbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/jbt_datapath.sv
// Datapath of the JSON byte tokenizer: parse registers, token table and result buffer.
`default_nettype none

module jbt_datapath #(
    parameter int MAX_TOKENS     = jbt_pkg::MAX_TOKENS_DEF,
    parameter int MAX_TEXT_BYTES = jbt_pkg::MAX_TEXT_BYTES_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_wdata,
    input  wire logic [jbt_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [jbt_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic      [jbt_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                                m_tlast,
    input  wire jbt_pkg::cmd_t                  cmd,
    output jbt_pkg::status_t                    status
);

    localparam int IDX_W = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
    localparam int CNT_W = $clog2(MAX_TOKENS + 1);
    localparam int CS_W  = IDX_W + 1;
    localparam int BP_W  = $clog2(MAX_TEXT_BYTES + 1);

    // Token entry layout, lowest bit first: open, parent, child, end, start, kind.
    localparam int E_PAR_LO  = 1;
    localparam int E_CH_LO   = E_PAR_LO + CS_W;
    localparam int E_END_LO  = E_CH_LO + CNT_W;
    localparam int E_ST_LO   = E_END_LO + BP_W;
    localparam int E_KIND_LO = E_ST_LO + BP_W;
    localparam int ENT_W     = E_KIND_LO + 2;

    logic [7:0]          byte_reg;
    logic                last_in_reg;
    logic                strict_reg;
    logic [CNT_W-1:0]    nft_reg, nft_next;
    logic [CS_W-1:0]     cs_reg, cs_next;
    logic [BP_W-1:0]     bp_reg, bp_next;
    logic                acf_reg, acf_next;
    jbt_pkg::mode_t      mode_reg, mode_next;
    logic [2:0]          hex_reg, hex_next;
    logic [BP_W-1:0]     ps_reg, ps_next;
    logic [CNT_W-1:0]    open_cnt_reg, open_cnt_next;
    logic [IDX_W-1:0]    rd_addr_reg;
    jbt_pkg::res_t       hold_reg, hold_next;
    logic                hold_valid_reg, hold_valid_next;
    jbt_pkg::res_t       out_reg, out_next;
    logic                out_last_reg, out_last_next;
    logic                out_valid_reg, out_valid_next;

    logic [ENT_W-1:0]    rdata, wdata;
    logic [IDX_W-1:0]    raddr, waddr;
    logic                we;
    jbt_pkg::tkind_t     rd_kind;
    logic [BP_W-1:0]     rd_st;
    logic [CNT_W-1:0]    rd_child;
    logic [CS_W-1:0]     rd_par;
    logic                rd_open;
    logic [CNT_W-1:0]    nft_m1;
    logic [BP_W-1:0]     bp_p1;
    logic                out_free;
    logic                is_ws, is_comma, is_colon, is_close;
    jbt_pkg::tkind_t     close_kind;
    jbt_pkg::tkind_t     w_kind;
    logic [BP_W-1:0]     w_st, w_end;
    logic [CNT_W-1:0]    w_child;
    logic [CS_W-1:0]     w_par;
    logic                w_open;
    jbt_pkg::res_t       new_res;
    logic signed [CS_W-1:0] cs_s, rd_par_s;

    assign nft_m1 = nft_reg - CNT_W'(1);
    assign bp_p1  = bp_reg + BP_W'(1);

    // Fields of the entry last read.
    assign rd_kind  = jbt_pkg::tkind_t'(rdata[E_KIND_LO +: 2]);
    assign rd_st    = rdata[E_ST_LO +: BP_W];
    assign rd_child = rdata[E_CH_LO +: CNT_W];
    assign rd_par   = rdata[E_PAR_LO +: CS_W];
    assign rd_open  = rdata[0];
    assign cs_s     = $signed(cs_reg);
    assign rd_par_s = $signed(rd_par);

    // Token table.
    always_comb begin
        case (cmd.rd_sel)
            jbt_pkg::RD_NFT_M1: raddr = nft_m1[IDX_W-1:0];
            jbt_pkg::RD_CS:     raddr = cs_reg[IDX_W-1:0];
            jbt_pkg::RD_PARENT: raddr = rd_par[IDX_W-1:0];
            default:            raddr = cs_reg[IDX_W-1:0];
        endcase
    end

    // Write data: a new token, a closing update or a child count increment.
    always_comb begin
        w_kind  = rd_kind;
        w_st    = rd_st;
        w_end   = rdata[E_END_LO +: BP_W];
        w_child = rd_child;
        w_par   = rd_par;
        w_open  = rd_open;
        waddr   = rd_addr_reg;
        if (cmd.new_tok) begin
            w_kind  = cmd.new_kind;
            w_st    = cmd.new_open ? bp_reg : ps_reg;
            w_end   = cmd.new_open ? '0 : bp_reg;
            w_child = '0;
            w_par   = cs_reg;
            w_open  = cmd.new_open;
            waddr   = nft_reg[IDX_W-1:0];
        end else if (cmd.close_wr) begin
            w_end  = bp_p1;
            w_open = 1'b0;
        end else if (cmd.inc_wr) begin
            w_child = rd_child + CNT_W'(1);
        end
    end

    assign wdata = {w_kind, w_st, w_end, w_child, w_par, w_open};
    assign we    = cmd.new_tok | cmd.close_wr | cmd.inc_wr;

    jbt_ram #(
        .WIDTH(ENT_W),
        .DEPTH(MAX_TOKENS)
    ) u_table (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (cmd.rd_en),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_addr_reg <= raddr;
        end
    end

    // Input word and configuration register.
    always_ff @(posedge aclk) begin
        if (cmd.load_byte) begin
            byte_reg    <= s_tdata;
            last_in_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strict_reg <= 1'b0;
        end else if (cfg_we) begin
            strict_reg <= cfg_wdata;
        end
    end

    // Parse state next values.
    always_comb begin
        nft_next      = nft_reg;
        cs_next       = cs_reg;
        bp_next       = bp_reg;
        acf_next      = acf_reg;
        mode_next     = mode_reg;
        hex_next      = hex_reg;
        ps_next       = ps_reg;
        open_cnt_next = open_cnt_reg;
        if (cmd.restart) begin
            nft_next      = '0;
            cs_next       = '1;
            bp_next       = '0;
            acf_next      = 1'b0;
            mode_next     = jbt_pkg::MODE_IDLE;
            hex_next      = '0;
            ps_next       = '0;
            open_cnt_next = '0;
        end else begin
            if (cmd.new_tok) begin
                nft_next = nft_reg + CNT_W'(1);
            end
            case (cmd.cs_sel)
                jbt_pkg::CS_NFT_M1:    cs_next = CS_W'(nft_reg) - CS_W'(1);
                jbt_pkg::CS_RD_PARENT: cs_next = rd_par;
                jbt_pkg::CS_NFT:       cs_next = CS_W'(nft_reg);
                default:               cs_next = cs_reg;
            endcase
            if (cmd.bp_inc) begin
                bp_next = bp_p1;
            end
            if (cmd.acf_set) begin
                acf_next = 1'b1;
            end else if (cmd.acf_clr) begin
                acf_next = 1'b0;
            end
            if (cmd.fail) begin
                mode_next = jbt_pkg::MODE_HALT;
            end else if (cmd.mode_we) begin
                mode_next = cmd.mode_val;
            end
            if (cmd.hex_load) begin
                hex_next = 3'd4;
            end else if (cmd.hex_dec) begin
                hex_next = hex_reg - 3'd1;
            end
            case (cmd.ps_sel)
                jbt_pkg::PS_BP:  ps_next = bp_reg;
                jbt_pkg::PS_BP1: ps_next = bp_p1;
                default:         ps_next = ps_reg;
            endcase
            if (cmd.open_inc) begin
                open_cnt_next = open_cnt_reg + CNT_W'(1);
            end else if (cmd.open_dec) begin
                open_cnt_next = open_cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nft_reg      <= '0;
            cs_reg       <= '1;
            bp_reg       <= '0;
            acf_reg      <= 1'b0;
            mode_reg     <= jbt_pkg::MODE_IDLE;
            hex_reg      <= '0;
            ps_reg       <= '0;
            open_cnt_reg <= '0;
        end else begin
            nft_reg      <= nft_next;
            cs_reg       <= cs_next;
            bp_reg       <= bp_next;
            acf_reg      <= acf_next;
            mode_reg     <= mode_next;
            hex_reg      <= hex_next;
            ps_reg       <= ps_next;
            open_cnt_reg <= open_cnt_next;
        end
    end

    // Result word built from the command.
    always_comb begin
        new_res = '0;
        if (cmd.fail) begin
            new_res.ev   = jbt_pkg::EV_ERROR;
            new_res.code = cmd.err_code;
        end else begin
            case (cmd.push_sel)
                jbt_pkg::PUSH_NEW: begin
                    new_res.ev     = cmd.push_ev;
                    new_res.idx    = 6'(nft_reg[IDX_W-1:0]);
                    new_res.kind   = cmd.new_kind;
                    new_res.startp = 16'(cmd.new_open ? bp_reg : ps_reg);
                    new_res.endp   = 17'(cmd.new_open ? '0 : bp_reg);
                    new_res.parent = 7'(cs_s);
                end
                jbt_pkg::PUSH_CLOSED: begin
                    new_res.ev     = jbt_pkg::EV_CLOSED;
                    new_res.idx    = 6'(rd_addr_reg);
                    new_res.kind   = rd_kind;
                    new_res.startp = 16'(rd_st);
                    new_res.endp   = 17'(bp_p1);
                    new_res.parent = 7'(rd_par_s);
                    new_res.child  = 7'(rd_child);
                end
                jbt_pkg::PUSH_DONE: begin
                    new_res.ev    = jbt_pkg::EV_DONE;
                    new_res.child = 7'(nft_reg);
                    new_res.code  = ((mode_reg != jbt_pkg::MODE_IDLE) || (open_cnt_reg != '0))
                                    ? jbt_pkg::ERR_PARTIAL : jbt_pkg::ERR_NONE;
                end
                default: new_res = '0;
            endcase
        end
    end

    // Hold stage and output register; the held word goes out once the next
    // word or the end of the byte tells whether it was the last one.
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.push || cmd.fail) begin
            if (hold_valid_reg) begin
                out_next       = hold_reg;
                out_last_next  = 1'b0;
                out_valid_next = 1'b1;
            end
            hold_next       = new_res;
            hold_valid_next = 1'b1;
        end else if (cmd.flush && hold_valid_reg) begin
            out_next        = hold_reg;
            out_last_next   = 1'b1;
            out_valid_next  = 1'b1;
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        hold_reg     <= hold_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_reg.ev;
    assign m_tdata  = {7'b0, out_reg.code, out_reg.child, out_reg.parent, out_reg.endp,
                       out_reg.startp, out_reg.kind, out_reg.idx};

    // Byte classes.
    assign is_ws    = (byte_reg == jbt_pkg::CH_TAB) || (byte_reg == jbt_pkg::CH_CR) ||
                      (byte_reg == jbt_pkg::CH_LF) || (byte_reg == jbt_pkg::CH_SPACE);
    assign is_comma = (byte_reg == jbt_pkg::CH_COMMA);
    assign is_colon = (byte_reg == jbt_pkg::CH_COLON);
    assign is_close = (byte_reg == jbt_pkg::CH_RBRACE) || (byte_reg == jbt_pkg::CH_RBRACKET);
    assign close_kind = (byte_reg == jbt_pkg::CH_RBRACE) ? jbt_pkg::TK_OBJECT
                                                          : jbt_pkg::TK_ARRAY;

    always_comb begin
        status               = '0;
        status.zero          = (byte_reg == 8'd0);
        status.last          = last_in_reg || (byte_reg == 8'd0);
        status.overlong      = (bp_reg >= BP_W'(MAX_TEXT_BYTES));
        status.mode          = mode_reg;
        status.is_quote      = (byte_reg == jbt_pkg::CH_QUOTE);
        status.is_bslash     = (byte_reg == jbt_pkg::CH_BSLASH);
        status.is_esc_ok     = (byte_reg == jbt_pkg::CH_QUOTE) ||
                               (byte_reg == jbt_pkg::CH_SLASH) ||
                               (byte_reg == jbt_pkg::CH_BSLASH) ||
                               (byte_reg == jbt_pkg::CH_B) || (byte_reg == jbt_pkg::CH_F) ||
                               (byte_reg == jbt_pkg::CH_R) || (byte_reg == jbt_pkg::CH_N) ||
                               (byte_reg == jbt_pkg::CH_T);
        status.is_u          = (byte_reg == jbt_pkg::CH_U);
        status.is_hex        = ((byte_reg >= jbt_pkg::CH_DIGIT_0) &&
                                (byte_reg <= jbt_pkg::CH_DIGIT_9)) ||
                               ((byte_reg >= jbt_pkg::CH_UPPER_A) &&
                                (byte_reg <= jbt_pkg::CH_UPPER_F)) ||
                               ((byte_reg >= jbt_pkg::CH_LOWER_A) &&
                                (byte_reg <= jbt_pkg::CH_LOWER_F));
        status.is_ws         = is_ws;
        status.is_delim      = is_ws || is_comma || is_close || (is_colon && !strict_reg);
        status.is_ctl        = (byte_reg < jbt_pkg::CH_SPACE) || (byte_reg >= jbt_pkg::CH_DEL);
        status.is_open       = (byte_reg == jbt_pkg::CH_LBRACE) ||
                               (byte_reg == jbt_pkg::CH_LBRACKET);
        status.is_obj_open   = (byte_reg == jbt_pkg::CH_LBRACE);
        status.is_close      = is_close;
        status.is_colon      = is_colon;
        status.is_comma      = is_comma;
        status.is_prim_start = (byte_reg == jbt_pkg::CH_MINUS) ||
                               ((byte_reg >= jbt_pkg::CH_DIGIT_0) &&
                                (byte_reg <= jbt_pkg::CH_DIGIT_9)) ||
                               (byte_reg == jbt_pkg::CH_T) || (byte_reg == jbt_pkg::CH_F) ||
                               (byte_reg == jbt_pkg::CH_N);
        status.strict        = strict_reg;
        status.can_push      = !hold_valid_reg || out_free;
        status.nft_zero      = (nft_reg == '0);
        status.nft_full      = (nft_reg >= CNT_W'(MAX_TOKENS));
        status.cs_valid      = !cs_reg[CS_W-1];
        status.cs_top        = (cs_reg == '1);
        status.acf           = acf_reg;
        status.hex_one       = (hex_reg == 3'd1);
        status.rd_open       = rd_open;
        status.rd_kind_match = (rd_kind == close_kind);
        status.rd_par_top    = (rd_par == '1);
        status.rd_par_ok     = !rd_par[CS_W-1] && (CNT_W'(rd_par[IDX_W-1:0]) < nft_reg);
        status.rd_kind       = rd_kind;
        status.rd_child_zero = (rd_child == '0);
    end

endmodule

`default_nettype wire

// File: rtl/jbt_ctrl.sv
// Controller state machine of the JSON byte tokenizer.
`default_nettype none

module jbt_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire jbt_pkg::status_t status,
    output jbt_pkg::cmd_t         cmd
);

    jbt_pkg::ctrl_state_t state_reg, state_next;
    jbt_pkg::ctrl_state_t ret_reg, ret_next;

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= jbt_pkg::ST_IDLE;
            ret_reg   <= jbt_pkg::ST_ADV;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            jbt_pkg::ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.load_byte = s_tvalid;
                if (s_tvalid) begin
                    state_next = jbt_pkg::ST_DISPATCH;
                end
            end

            // Content byte in the current lexer mode.
            jbt_pkg::ST_DISPATCH: begin
                if (status.can_push) begin
                    if (status.zero || (status.mode == jbt_pkg::MODE_HALT)) begin
                        state_next = jbt_pkg::ST_END;
                    end else if (status.overlong) begin
                        cmd.fail     = 1'b1;
                        cmd.err_code = jbt_pkg::ERR_INVALID;
                        state_next   = jbt_pkg::ST_END;
                    end else begin
                        state_next = jbt_pkg::ST_ADV;
                        case (status.mode)
                            jbt_pkg::MODE_STR: begin
                                if (status.is_quote) begin
                                    state_next = jbt_pkg::ST_NEW_STR;
                                end else if (status.is_bslash) begin
                                    cmd.mode_we  = 1'b1;
                                    cmd.mode_val = jbt_pkg::MODE_ESC;
                                end
                            end
                            jbt_pkg::MODE_ESC: begin
                                if (status.is_esc_ok) begin
                                    cmd.mode_we  = 1'b1;
                                    cmd.mode_val = jbt_pkg::MODE_STR;
                                end else if (status.is_u) begin
                                    cmd.hex_load = 1'b1;
                                    cmd.mode_we  = 1'b1;
                                    cmd.mode_val = jbt_pkg::MODE_HEX;
                                end else begin
                                    cmd.fail     = 1'b1;
                                    cmd.err_code = jbt_pkg::ERR_INVALID;
                                end
                            end
                            jbt_pkg::MODE_HEX: begin
                                if (!status.is_hex) begin
                                    cmd.fail     = 1'b1;
                                    cmd.err_code = jbt_pkg::ERR_INVALID;
                                end else begin
                                    cmd.hex_dec = 1'b1;
                                    if (status.hex_one) begin
                                        cmd.mode_we  = 1'b1;
                                        cmd.mode_val = jbt_pkg::MODE_STR;
                                    end
                                end
                            end
                            jbt_pkg::MODE_PRIM: begin
                                if (status.is_delim) begin
                                    state_next = jbt_pkg::ST_NEW_PRIM;
                                end else if (status.is_ctl) begin
                                    cmd.fail     = 1'b1;
                                    cmd.err_code = jbt_pkg::ERR_INVALID;
                                end
                            end
                            default: begin
                                state_next = jbt_pkg::ST_IDLE_BYTE;
                            end
                        endcase
                    end
                end
            end

            // Byte between tokens.
            jbt_pkg::ST_IDLE_BYTE: begin
                if (status.can_push) begin
                    state_next = jbt_pkg::ST_ADV;
                    if (status.is_open) begin
                        cmd.acf_clr = 1'b1;
                        state_next  = jbt_pkg::ST_NEW_CONT;
                    end else if (status.is_close) begin
                        cmd.acf_clr = 1'b1;
                        if (status.nft_zero) begin
                            cmd.fail     = 1'b1;
                            cmd.err_code = jbt_pkg::ERR_INVALID;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = jbt_pkg::RD_NFT_M1;
                            state_next = jbt_pkg::ST_WALK;
                        end
                    end else if (status.is_quote) begin
                        cmd.ps_sel   = jbt_pkg::PS_BP1;
                        cmd.mode_we  = 1'b1;
                        cmd.mode_val = jbt_pkg::MODE_STR;
                    end else if (status.is_ws) begin
                        cmd.bp_inc = 1'b0;
                    end else if (status.is_colon) begin
                        if (!status.acf) begin
                            cmd.cs_sel  = jbt_pkg::CS_NFT_M1;
                            cmd.acf_set = 1'b1;
                        end
                    end else if (status.is_comma) begin
                        cmd.acf_clr = 1'b1;
                        if (status.cs_valid) begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = jbt_pkg::RD_CS;
                            state_next = jbt_pkg::ST_COMMA;
                        end
                    end else if (status.strict && !status.is_prim_start) begin
                        cmd.fail     = 1'b1;
                        cmd.err_code = jbt_pkg::ERR_INVALID;
                    end else if (status.strict && status.cs_valid) begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = jbt_pkg::RD_CS;
                        state_next = jbt_pkg::ST_STRICT;
                    end else if (status.is_ctl) begin
                        cmd.fail     = 1'b1;
                        cmd.err_code = jbt_pkg::ERR_INVALID;
                    end else begin
                        cmd.ps_sel   = jbt_pkg::PS_BP;
                        cmd.mode_we  = 1'b1;
                        cmd.mode_val = jbt_pkg::MODE_PRIM;
                    end
                end
            end

            // New token: container, string, primitive or primitive at end of text.
            jbt_pkg::ST_NEW_CONT, jbt_pkg::ST_NEW_STR, jbt_pkg::ST_NEW_PRIM,
            jbt_pkg::ST_NEW_EPRIM: begin
                if (status.can_push) begin
                    if (status.nft_full) begin
                        cmd.fail     = 1'b1;
                        cmd.err_code = jbt_pkg::ERR_NO_TOKENS;
                        state_next   = (state_reg == jbt_pkg::ST_NEW_EPRIM) ?
                                       jbt_pkg::ST_END : jbt_pkg::ST_ADV;
                    end else begin
                        cmd.new_tok  = 1'b1;
                        cmd.push     = 1'b1;
                        cmd.push_sel = jbt_pkg::PUSH_NEW;
                        case (state_reg)
                            jbt_pkg::ST_NEW_CONT: begin
                                cmd.new_open = 1'b1;
                                cmd.new_kind = status.is_obj_open ? jbt_pkg::TK_OBJECT
                                                                  : jbt_pkg::TK_ARRAY;
                                cmd.push_ev  = jbt_pkg::EV_OPENED;
                                cmd.cs_sel   = jbt_pkg::CS_NFT;
                                cmd.open_inc = 1'b1;
                                ret_next     = jbt_pkg::ST_ADV;
                            end
                            jbt_pkg::ST_NEW_STR: begin
                                cmd.new_kind = jbt_pkg::TK_STRING;
                                cmd.push_ev  = jbt_pkg::EV_STRING;
                                ret_next     = jbt_pkg::ST_ADV;
                            end
                            jbt_pkg::ST_NEW_PRIM: begin
                                cmd.new_kind = jbt_pkg::TK_PRIM;
                                cmd.push_ev  = jbt_pkg::EV_PRIM;
                                ret_next     = jbt_pkg::ST_IDLE_BYTE;
                            end
                            default: begin
                                cmd.new_kind = jbt_pkg::TK_PRIM;
                                cmd.push_ev  = jbt_pkg::EV_PRIM;
                                ret_next     = jbt_pkg::ST_DONE;
                            end
                        endcase
                        if (state_reg != jbt_pkg::ST_NEW_CONT) begin
                            cmd.acf_clr  = 1'b1;
                            cmd.mode_we  = 1'b1;
                            cmd.mode_val = jbt_pkg::MODE_IDLE;
                        end
                        // The enclosing token gains a child.
                        if (status.cs_valid) begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = jbt_pkg::RD_CS;
                            state_next = jbt_pkg::ST_INC;
                        end else begin
                            state_next = ret_next;
                        end
                    end
                end
            end

            jbt_pkg::ST_INC: begin
                cmd.inc_wr = 1'b1;
                state_next = ret_reg;
            end

            // Closing bracket: follow parent links from the newest token.
            jbt_pkg::ST_WALK: begin
                if (status.can_push) begin
                    state_next = jbt_pkg::ST_ADV;
                    if (status.rd_open) begin
                        if (!status.rd_kind_match) begin
                            cmd.fail     = 1'b1;
                            cmd.err_code = jbt_pkg::ERR_INVALID;
                        end else begin
                            cmd.close_wr = 1'b1;
                            cmd.cs_sel   = jbt_pkg::CS_RD_PARENT;
                            cmd.open_dec = 1'b1;
                            cmd.push     = 1'b1;
                            cmd.push_sel = jbt_pkg::PUSH_CLOSED;
                        end
                    end else if (status.rd_par_top) begin
                        if (!status.rd_kind_match || status.cs_top) begin
                            cmd.fail     = 1'b1;
                            cmd.err_code = jbt_pkg::ERR_INVALID;
                        end
                    end else if (!status.rd_par_ok) begin
                        cmd.fail     = 1'b1;
                        cmd.err_code = jbt_pkg::ERR_INVALID;
                    end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = jbt_pkg::RD_PARENT;
                        state_next = jbt_pkg::ST_WALK;
                    end
                end
            end

            // Comma after a key or value leaf moves back to its container.
            jbt_pkg::ST_COMMA: begin
                if ((status.rd_kind == jbt_pkg::TK_PRIM) ||
                    (status.rd_kind == jbt_pkg::TK_STRING)) begin
                    cmd.cs_sel = jbt_pkg::CS_RD_PARENT;
                end
                state_next = jbt_pkg::ST_ADV;
            end

            // Strict mode: a primitive may not be a key.
            jbt_pkg::ST_STRICT: begin
                if (status.can_push) begin
                    state_next = jbt_pkg::ST_ADV;
                    if ((status.rd_kind == jbt_pkg::TK_OBJECT) ||
                        ((status.rd_kind == jbt_pkg::TK_STRING) && !status.rd_child_zero)) begin
                        cmd.fail     = 1'b1;
                        cmd.err_code = jbt_pkg::ERR_INVALID;
                    end else if (status.is_ctl) begin
                        cmd.fail     = 1'b1;
                        cmd.err_code = jbt_pkg::ERR_INVALID;
                    end else begin
                        cmd.ps_sel   = jbt_pkg::PS_BP;
                        cmd.mode_we  = 1'b1;
                        cmd.mode_val = jbt_pkg::MODE_PRIM;
                    end
                end
            end

            jbt_pkg::ST_ADV: begin
                cmd.bp_inc = 1'b1;
                state_next = jbt_pkg::ST_END;
            end

            // End of the byte, and of the document when the byte is the last one.
            jbt_pkg::ST_END: begin
                if (!status.last) begin
                    state_next = jbt_pkg::ST_FLUSH;
                end else if (status.mode == jbt_pkg::MODE_HALT) begin
                    cmd.restart = 1'b1;
                    state_next  = jbt_pkg::ST_FLUSH;
                end else if ((status.mode == jbt_pkg::MODE_PRIM) && !status.strict) begin
                    state_next = jbt_pkg::ST_NEW_EPRIM;
                end else begin
                    state_next = jbt_pkg::ST_DONE;
                end
            end

            jbt_pkg::ST_DONE: begin
                if (status.can_push) begin
                    cmd.push     = 1'b1;
                    cmd.push_sel = jbt_pkg::PUSH_DONE;
                    cmd.restart  = 1'b1;
                    state_next   = jbt_pkg::ST_FLUSH;
                end
            end

            // Release the held word marked as the last of this byte.
            jbt_pkg::ST_FLUSH: begin
                if (status.can_push) begin
                    cmd.flush  = 1'b1;
                    state_next = jbt_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = jbt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/json_byte_tokenizer_unit.sv
// Top level of the JSON byte tokenizer.
`default_nettype none

// Streaming JSON tokenizer. Bytes of text arrive one word at a time on the
// s_ channel (s_tlast marks the last byte of a document, a zero byte also
// ends it); the m_ channel delivers one word per event: opened and closed
// containers, finished strings and primitives, errors and the done word at
// the end of a document, with m_tlast on the final word caused by one byte.
// The block handles one byte at a time. A byte between tokens also passes
// the between-token state, which a byte inside a string or a primitive
// skips. Writing a token adds a step, and one more when an enclosing
// container counts it as a child; a primitive ended by a delimiter then also
// passes the between-token state for that delimiter. A comma inside a
// container adds a table read, a primitive started inside a container in
// strict mode adds one, and a closing bracket adds one for each token visited
// on the way to its open container, as each step uses the single read port
// of the token table. The end of a document adds a step for the done word,
// plus the token steps of a primitive finished there. Results wait in a hold
// stage and an output register, so a stalled m_ channel only pauses the
// block. strict_mode must be written through cfg_we and cfg_wdata only while
// no document byte is in flight; the block itself does not enforce this.
module json_byte_tokenizer_unit #(
    parameter int MAX_TOKENS     = jbt_pkg::MAX_TOKENS_DEF,
    parameter int MAX_TEXT_BYTES = jbt_pkg::MAX_TEXT_BYTES_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_wdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [jbt_pkg::S_TDATA_W-1:0] s_tdata,   // text_byte[7:0]
    input  wire logic                          s_tlast,   // end_of_text
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // token_index[5:0], token_kind[7:6], start_pos[23:8], end_pos[40:24],
    // parent_index[47:41], child_count[54:48], error_code[56:55], zeros above
    output logic      [jbt_pkg::M_TDATA_W-1:0] m_tdata,
    output logic      [jbt_pkg::M_TUSER_W-1:0] m_tuser,   // event_kind[2:0]
    output logic                               m_tlast    // last_result
);

    jbt_pkg::cmd_t    cmd;
    jbt_pkg::status_t status;

    jbt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    jbt_datapath #(
        .MAX_TOKENS    (MAX_TOKENS),
        .MAX_TEXT_BYTES(MAX_TEXT_BYTES)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

`default_nettype wire
